// ----- rtl/core/abhd_pkg.sv -----
// ----------------------------------------------------------------------------
// abhd_pkg
// Shared constants, tables, types and control structs of the detection head
// decoder.
// ----------------------------------------------------------------------------
package abhd_pkg;

  localparam int INPUT_SIZE  = 640;
  localparam int NUM_LEVELS  = 3;
  localparam int NUM_ANCHORS = 3;

  localparam logic [15:0] THR_RESET = 16'd42598;

  // Iterations of the shared sigmoid unit
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 17;

  // Grid cells per side for each level, clamped to 1..128
  localparam int GRID_RAW_L0 = INPUT_SIZE / 8;
  localparam int GRID_RAW_L1 = INPUT_SIZE / 16;
  localparam int GRID_RAW_L2 = INPUT_SIZE / 32;
  localparam logic [7:0] GRID_L0 =
    8'((GRID_RAW_L0 < 1) ? 1 : ((GRID_RAW_L0 > 128) ? 128 : GRID_RAW_L0));
  localparam logic [7:0] GRID_L1 =
    8'((GRID_RAW_L1 < 1) ? 1 : ((GRID_RAW_L1 > 128) ? 128 : GRID_RAW_L1));
  localparam logic [7:0] GRID_L2 =
    8'((GRID_RAW_L2 < 1) ? 1 : ((GRID_RAW_L2 > 128) ? 128 : GRID_RAW_L2));

  // exp(-2^(k-8)) in Q0.32
  localparam logic [31:0] EXP_NEG_Q32 [MUL_STEPS] = '{
    32'd4278222805, 32'd4261543596, 32'd4228379999, 32'd4162825043,
    32'd4034748382, 32'd3790295337, 32'd3344923893, 32'd2605029346,
    32'd1580030179, 32'd581260607,  32'd78665069,   32'd1440791,
    32'd483,        32'd0,          32'd0,          32'd0
  };

  // Anchor width/height pairs per level
  localparam logic [8:0] ANCHOR_DIMS [NUM_LEVELS][NUM_ANCHORS * 2] = '{
    '{9'd10,  9'd13,  9'd16,  9'd30,  9'd33,  9'd23},
    '{9'd30,  9'd61,  9'd62,  9'd45,  9'd59,  9'd119},
    '{9'd116, 9'd90,  9'd156, 9'd198, 9'd373, 9'd326}
  };

  localparam logic [1:0] LEVEL_LAST  = 2'(NUM_LEVELS - 1);
  localparam logic [1:0] ANCHOR_LAST = 2'(NUM_ANCHORS - 1);

  typedef enum logic [2:0] {
    SEL_OBJ,
    SEL_X,
    SEL_Y,
    SEL_W,
    SEL_H
  } sig_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIG_START,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SIG_STORE,
    ST_SQ_W,
    ST_SZ_W,
    ST_SQ_H,
    ST_SZ_H,
    ST_EMIT,
    ST_SKIP
  } state_t;

  typedef struct packed {
    logic       load;
    logic       sig_start;
    logic       mul_step;
    logic       div_load;
    logic       div_step;
    logic       sig_store;
    logic       sq_w;
    logic       sz_w;
    logic       sq_h;
    logic       sz_h;
    logic       emit;
    logic       advance;
    sig_sel_t   sel;
    logic [3:0] bit_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic pass;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] grid_cells(input logic [1:0] lvl);
    logic [7:0] g;
    case (lvl)
      2'd0:    g = GRID_L0;
      2'd1:    g = GRID_L1;
      default: g = GRID_L2;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/abhd_if.sv -----
// ----------------------------------------------------------------------------
// abhd channel interfaces
// Logit input channel, box output channel and threshold write channel.
// ----------------------------------------------------------------------------
interface abhd_logit_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [15:0] logit_x;
  logic signed [15:0] logit_y;
  logic signed [15:0] logit_w;
  logic signed [15:0] logit_h;
  logic signed [15:0] logit_obj;

  modport source (output valid, frame_start, logit_x, logit_y, logit_w, logit_h,
                  logit_obj, input ready);
  modport sink   (input valid, frame_start, logit_x, logit_y, logit_w, logit_h,
                  logit_obj, output ready);
endinterface

interface abhd_box_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] center_x;
  logic signed [14:0] center_y;
  logic        [14:0] box_width;
  logic        [14:0] box_height;
  logic        [15:0] score;
  logic        [1:0]  scale_level;

  modport source (output valid, center_x, center_y, box_width, box_height, score,
                  scale_level, input ready);
  modport sink   (input valid, center_x, center_y, box_width, box_height, score,
                  scale_level, output ready);
endinterface

interface abhd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/abhd_ctrl.sv -----
// ----------------------------------------------------------------------------
// abhd_ctrl
// Sequencer: steps the shared sigmoid unit over objectness, and for a passing
// cell over the other four logits and the box size unit, then hands the box to the output register.
// ----------------------------------------------------------------------------
module abhd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  abhd_pkg::dp_status_t status,
  output abhd_pkg::dp_cmd_t   cmd
);

  localparam logic [4:0] MUL_LAST = 5'(abhd_pkg::MUL_STEPS - 1);
  localparam logic [4:0] DIV_LAST = 5'(abhd_pkg::DIV_STEPS - 1);

  abhd_pkg::state_t   state, state_next;
  abhd_pkg::sig_sel_t sel, sel_next;
  logic [4:0]         cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abhd_pkg::ST_IDLE;
      sel   <= abhd_pkg::SEL_OBJ;
      cnt   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next  = state;
    sel_next    = sel;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.sel     = sel;
    cmd.bit_idx = cnt[3:0];
    case (state)
      abhd_pkg::ST_IDLE: begin
        // take no cell while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          sel_next   = abhd_pkg::SEL_OBJ;
          state_next = abhd_pkg::ST_SIG_START;
        end
      end
      abhd_pkg::ST_SIG_START: begin
        cmd.sig_start = 1'b1;
        cnt_next      = '0;
        state_next    = abhd_pkg::ST_MUL;
      end
      abhd_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == MUL_LAST) begin
          cnt_next   = '0;
          state_next = abhd_pkg::ST_DIV_LOAD;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      abhd_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = abhd_pkg::ST_DIV;
      end
      abhd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = abhd_pkg::ST_SIG_STORE;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      abhd_pkg::ST_SIG_STORE: begin
        cmd.sig_store = 1'b1;
        case (sel)
          abhd_pkg::SEL_OBJ: begin
            if (status.pass) begin
              sel_next   = abhd_pkg::SEL_X;
              state_next = abhd_pkg::ST_SIG_START;
            end else begin
              state_next = abhd_pkg::ST_SKIP;
            end
          end
          abhd_pkg::SEL_X: begin
            sel_next   = abhd_pkg::SEL_Y;
            state_next = abhd_pkg::ST_SIG_START;
          end
          abhd_pkg::SEL_Y: begin
            sel_next   = abhd_pkg::SEL_W;
            state_next = abhd_pkg::ST_SIG_START;
          end
          abhd_pkg::SEL_W: begin
            sel_next   = abhd_pkg::SEL_H;
            state_next = abhd_pkg::ST_SIG_START;
          end
          default: begin
            state_next = abhd_pkg::ST_SQ_W;
          end
        endcase
      end
      abhd_pkg::ST_SQ_W: begin
        cmd.sq_w   = 1'b1;
        state_next = abhd_pkg::ST_SZ_W;
      end
      abhd_pkg::ST_SZ_W: begin
        cmd.sz_w   = 1'b1;
        state_next = abhd_pkg::ST_SQ_H;
      end
      abhd_pkg::ST_SQ_H: begin
        cmd.sq_h   = 1'b1;
        state_next = abhd_pkg::ST_SZ_H;
      end
      abhd_pkg::ST_SZ_H: begin
        cmd.sz_h   = 1'b1;
        state_next = abhd_pkg::ST_EMIT;
      end
      abhd_pkg::ST_EMIT: begin
        // hold until the output register can take the box
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.advance = 1'b1;
          state_next  = abhd_pkg::ST_IDLE;
        end
      end
      abhd_pkg::ST_SKIP: begin
        cmd.advance = 1'b1;
        state_next  = abhd_pkg::ST_IDLE;
      end
      default: begin
        state_next = abhd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/abhd_datapath.sv -----
// ----------------------------------------------------------------------------
// abhd_datapath
// Position counters, iterative sigmoid (multiply chain plus restoring
// division), box arithmetic, threshold register and output register.
// ----------------------------------------------------------------------------
module abhd_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  abhd_pkg::dp_cmd_t    cmd,
  output abhd_pkg::dp_status_t status,
  input  logic                 frame_start,
  input  logic signed [15:0]   logit_x,
  input  logic signed [15:0]   logit_y,
  input  logic signed [15:0]   logit_w,
  input  logic signed [15:0]   logit_h,
  input  logic signed [15:0]   logit_obj,
  abhd_cfg_if.sink             cfg,
  abhd_box_if.source           boxes
);

  // Captured logits
  logic [15:0] lx, ly, lw, lh, lobj;

  // Sigmoid unit
  logic [15:0] raw;
  logic [15:0] mag;
  logic        neg;
  logic [32:0] p;
  logic [64:0] prod;
  logic [33:0] den;
  logic [33:0] den_w;
  logic [48:0] num_w;
  logic [48:0] n_w;
  logic [33:0] rem;
  logic [16:0] dq;
  logic [34:0] rem2;
  logic [35:0] diff;
  logic        ge;
  logic [15:0] sig_sat;

  // Stored sigmoid results
  logic [15:0] s_obj, s_x, s_y, s_w, s_h;

  // Size unit
  logic [16:0] t_sel;
  logic [33:0] sq;
  logic [8:0]  anchor;
  logic [42:0] sz_prod;
  logic [43:0] sz_round;
  logic [15:0] sz_v;
  logic [14:0] sz_sat;
  logic [14:0] w_q4, h_q4;

  // Position counters
  logic [1:0] level_index, level_next;
  logic [1:0] anchor_index, anchor_next;
  logic [6:0] row_index, row_next;
  logic [6:0] col_index, col_next;
  logic [1:0] lvl_e, anc_e;
  logic [7:0] grid;
  logic [6:0] col_inc, row_inc;
  logic [1:0] anc_inc, lvl_inc;

  logic [15:0] thr;
  logic        box_valid;

  function automatic logic [14:0] centre_q4(input logic [15:0] s, input logic [6:0] pos,
                                            input logic [1:0] lvl);
    logic [23:0]        u;
    logic [28:0]        scaled;
    logic [29:0]        rounded;
    logic [17:0]        t;
    logic signed [19:0] off;
    logic signed [19:0] q;
    logic [14:0]        r;
    u = 24'({pos, 16'b0}) + 24'({s, 1'b0});
    case (lvl)
      2'd0:    begin scaled = 29'({u, 3'b0}); off = 20'sd64;  end
      2'd1:    begin scaled = 29'({u, 4'b0}); off = 20'sd128; end
      default: begin scaled = {u, 5'b0};      off = 20'sd256; end
    endcase
    rounded = 30'(scaled) + 30'd2048;
    t = rounded[29:12];
    q = $signed({2'b00, t}) - off;
    if (q > 20'sd16383) begin
      r = 15'h3FFF;
    end else if (q < -20'sd16384) begin
      r = 15'h4000;
    end else begin
      r = q[14:0];
    end
    return r;
  endfunction

  // ---- sigmoid unit ----
  always_comb begin
    case (cmd.sel)
      abhd_pkg::SEL_OBJ: raw = lobj;
      abhd_pkg::SEL_X:   raw = lx;
      abhd_pkg::SEL_Y:   raw = ly;
      abhd_pkg::SEL_W:   raw = lw;
      abhd_pkg::SEL_H:   raw = lh;
      default:           raw = lobj;
    endcase
  end

  assign prod  = 65'(p) * 65'(abhd_pkg::EXP_NEG_Q32[cmd.bit_idx]);
  assign den_w = 34'(p) + 34'h1_0000_0000;
  assign num_w = neg ? 49'({p, 16'b0}) : 49'h1_0000_0000_0000;
  assign n_w   = num_w + 49'(den_w >> 1);
  assign rem2  = {rem, dq[16]};
  assign diff  = {1'b0, rem2} - {2'b00, den};
  assign ge    = ~diff[35];
  assign sig_sat = dq[16] ? 16'hFFFF : dq[15:0];

  assign status.pass     = (sig_sat >= thr);
  assign status.out_free = ~box_valid | boxes.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lx   <= logit_x;
      ly   <= logit_y;
      lw   <= logit_w;
      lh   <= logit_h;
      lobj <= logit_obj;
    end
    if (cmd.sig_start) begin
      neg <= raw[15];
      mag <= raw[15] ? (16'd0 - raw) : raw;
      p   <= 33'h1_0000_0000;
    end
    if (cmd.mul_step && mag[cmd.bit_idx]) begin
      p <= prod[64:32];
    end
    if (cmd.div_load) begin
      den <= den_w;
      rem <= 34'(n_w[48:17]);
      dq  <= n_w[16:0];
    end
    if (cmd.div_step) begin
      rem <= ge ? diff[33:0] : rem2[33:0];
      dq  <= {dq[15:0], ge};
    end
    if (cmd.sig_store) begin
      case (cmd.sel)
        abhd_pkg::SEL_OBJ: s_obj <= sig_sat;
        abhd_pkg::SEL_X:   s_x   <= sig_sat;
        abhd_pkg::SEL_Y:   s_y   <= sig_sat;
        abhd_pkg::SEL_W:   s_w   <= sig_sat;
        abhd_pkg::SEL_H:   s_h   <= sig_sat;
        default:           s_obj <= sig_sat;
      endcase
    end
  end

  // ---- size unit: square, then scale by anchor ----
  assign t_sel    = cmd.sq_w ? {s_w, 1'b0} : {s_h, 1'b0};
  assign anchor   = cmd.sz_w ? abhd_pkg::ANCHOR_DIMS[lvl_e][{anc_e, 1'b0}]
                             : abhd_pkg::ANCHOR_DIMS[lvl_e][{anc_e, 1'b1}];
  assign sz_prod  = 43'(sq) * 43'(anchor);
  assign sz_round = 44'(sz_prod) + 44'h800_0000;
  assign sz_v     = sz_round[43:28];
  assign sz_sat   = sz_v[15] ? 15'h7FFF : sz_v[14:0];

  always_ff @(posedge clk) begin
    if (cmd.sq_w || cmd.sq_h) begin
      sq <= 34'(t_sel) * 34'(t_sel);
    end
    if (cmd.sz_w) begin
      w_q4 <= sz_sat;
    end
    if (cmd.sz_h) begin
      h_q4 <= sz_sat;
    end
  end

  // ---- position counters ----
  assign lvl_e   = (level_index > abhd_pkg::LEVEL_LAST) ? 2'd0 : level_index;
  assign anc_e   = (anchor_index > abhd_pkg::ANCHOR_LAST) ? 2'd0 : anchor_index;
  assign grid    = abhd_pkg::grid_cells(lvl_e);
  assign col_inc = col_index + 7'd1;
  assign row_inc = row_index + 7'd1;
  assign anc_inc = (anc_e == abhd_pkg::ANCHOR_LAST) ? 2'd0 : anc_e + 2'd1;
  assign lvl_inc = (lvl_e == abhd_pkg::LEVEL_LAST) ? 2'd0 : lvl_e + 2'd1;

  always_comb begin
    col_next    = col_inc;
    row_next    = row_index;
    anchor_next = anc_e;
    level_next  = lvl_e;
    if (({1'b0, col_inc} >= grid) || (col_inc == 7'd0)) begin
      col_next = '0;
      row_next = row_inc;
      if (({1'b0, row_inc} >= grid) || (row_inc == 7'd0)) begin
        row_next    = '0;
        anchor_next = anc_inc;
        if (anc_e == abhd_pkg::ANCHOR_LAST) begin
          level_next = lvl_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.load && frame_start)) begin
      level_index  <= '0;
      anchor_index <= '0;
      row_index    <= '0;
      col_index    <= '0;
    end else if (cmd.advance) begin
      level_index  <= level_next;
      anchor_index <= anchor_next;
      row_index    <= row_next;
      col_index    <= col_next;
    end
  end

  // ---- threshold register ----
  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= abhd_pkg::THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (cmd.emit) begin
      box_valid <= 1'b1;
    end else if (boxes.ready) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      boxes.center_x    <= centre_q4(s_x, col_index, lvl_e);
      boxes.center_y    <= centre_q4(s_y, row_index, lvl_e);
      boxes.box_width   <= w_q4;
      boxes.box_height  <= h_q4;
      boxes.score       <= s_obj;
      boxes.scale_level <= lvl_e;
    end
  end

  assign boxes.valid = box_valid;

endmodule

// ----- rtl/core/anchor_box_head_decoder.sv -----
// ----------------------------------------------------------------------------
// anchor_box_head_decoder
// Detection head decode: one grid cell of five Q8.8 logits in, at most one
// box (Q.4 pixels, Q0.16 score, scale level) out.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   logits    in    valid / ready    frame_start, logit_x/y/w/h/obj
//   boxes     out   valid / ready    center_x/y, box_width/height, score,
//                                    scale_level
//   cfg       in    valid / ready    data (objectness threshold, Q0.16)
//
// Sequencing: each logit passes through the shared sigmoid unit (16 multiply
// steps over the exponent table, then 17 restoring-division steps), once for
// the objectness and four more times for a passing cell, followed by the box
// size unit; a cell whose objectness is below threshold yields no box.
// A box waits in the output register; the next cell transfers meanwhile and
// the block stalls only if a second box is ready before the first is taken.
// rst (synchronous) clears the sequencer, counters and output valid, and
// loads the threshold with 42598. cfg is ready whenever rst is low.
//
module anchor_box_head_decoder (
  input  logic        clk,
  input  logic        rst,
  abhd_logit_if.sink  logits,
  abhd_box_if.source  boxes,
  abhd_cfg_if.sink    cfg
);

  abhd_pkg::dp_cmd_t    cmd;
  abhd_pkg::dp_status_t status;
  logic                 in_ready;

  // Sequencer: owns the state machine, logit select and step counter
  abhd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (logits.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign logits.ready = in_ready;

  // Datapath: counters, sigmoid unit, box math, threshold, output register
  abhd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .frame_start (logits.frame_start),
    .logit_x     (logits.logit_x),
    .logit_y     (logits.logit_y),
    .logit_w     (logits.logit_w),
    .logit_h     (logits.logit_h),
    .logit_obj   (logits.logit_obj),
    .cfg         (cfg),
    .boxes       (boxes)
  );

endmodule

// ----- rtl/core/abhd_checker.sv -----
// ----------------------------------------------------------------------------
// abhd_checker
// Port-level checks of the detection head decoder, bound to the top level.
// ----------------------------------------------------------------------------
module abhd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] center_x,
  input logic [14:0] center_y,
  input logic [14:0] box_width,
  input logic [14:0] box_height,
  input logic [15:0] score,
  input logic [1:0]  scale_level,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  logic [15:0] thr_seen;

  // Track the threshold as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_seen <= abhd_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_seen <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("box valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable({center_x, center_y, box_width, box_height, score, scale_level}))
    else $error("box payload changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("cell accepted while previous cell still in work");

  a_score_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> score >= thr_seen)
    else $error("box emitted below threshold");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scale_level != 2'd3)
    else $error("box carries an unused scale level");

endmodule

bind anchor_box_head_decoder abhd_checker u_abhd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (logits.valid),
  .in_ready    (logits.ready),
  .out_valid   (boxes.valid),
  .out_ready   (boxes.ready),
  .center_x    (boxes.center_x),
  .center_y    (boxes.center_y),
  .box_width   (boxes.box_width),
  .box_height  (boxes.box_height),
  .score       (boxes.score),
  .scale_level (boxes.scale_level),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .cfg_data    (cfg.data)
);
